[src/qrv_pkg.sv]
// Package for the quaternion vector rotation pipeline.
// Holds the field widths, fixed-point constants and the payload structs.
// Used by every module under src; depends on nothing else.
`timescale 1ns / 1ps

package qrv_pkg;

  localparam int unsigned FIELD_W   = 16;
  // 16x16 partial products of q*(0,v).
  localparam int unsigned PROD1_W   = 2 * FIELD_W;
  // Sum of three 2^30-bounded products needs one extra bit.
  localparam int unsigned P_W       = PROD1_W + 1;
  // P x Q2.14 partial products of p*conj(q).
  localparam int unsigned PROD2_W   = P_W + FIELD_W;
  // Sum of four second-level products, with headroom.
  localparam int unsigned R_W       = PROD2_W + 2;
  localparam int unsigned FRAC_SHIFT = 28;

  localparam logic signed [R_W-1:0] ROUND_HALF = R_W'(1) <<< (FRAC_SHIFT - 1);
  localparam logic signed [R_W-1:0] SAT_MAX    = R_W'(32767);
  localparam logic signed [R_W-1:0] SAT_MIN    = -R_W'(32768);

  typedef struct packed {
    logic signed [FIELD_W-1:0] w;
    logic signed [FIELD_W-1:0] x;
    logic signed [FIELD_W-1:0] y;
    logic signed [FIELD_W-1:0] z;
  } quat_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] x;
    logic signed [FIELD_W-1:0] y;
    logic signed [FIELD_W-1:0] z;
  } vec_t;

  // Intermediate quaternion p = q*(0,v), fraction 14 bits.
  typedef struct packed {
    logic signed [P_W-1:0] w;
    logic signed [P_W-1:0] x;
    logic signed [P_W-1:0] y;
    logic signed [P_W-1:0] z;
  } pquat_t;

  // Vector part of r = p*conj(q), fraction 28 bits.
  typedef struct packed {
    logic signed [R_W-1:0] x;
    logic signed [R_W-1:0] y;
    logic signed [R_W-1:0] z;
  } rvec_t;

endpackage

[src/qrv_qv_mult.sv]
// First product stage pair: partial products and sums of p = q*(0,v).
// The quaternion is carried along for the second product.
// Depends on qrv_pkg.
`timescale 1ns / 1ps

module qrv_qv_mult (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          up_valid,
  output logic          up_ready,
  input  qrv_pkg::quat_t up_quat,
  input  qrv_pkg::vec_t  up_vec,
  output logic          dn_valid,
  input  logic          dn_ready,
  output qrv_pkg::quat_t dn_quat,
  output qrv_pkg::pquat_t dn_p
);
  import qrv_pkg::*;

  logic                      va_r;
  logic                      vb_r;
  logic                      en_a;
  logic                      en_b;
  quat_t                     qa_r;
  quat_t                     qb_r;
  pquat_t                    p_r;
  logic signed [PROD1_W-1:0] m_r [12];
  logic signed [PROD1_W-1:0] m_nxt [12];
  pquat_t                    p_nxt;

  // A stage takes a new transaction when it is empty or its content moves on.
  assign en_b     = !vb_r || dn_ready;
  assign en_a     = !va_r || en_b;
  assign up_ready = en_a;

  always_comb begin
    m_nxt[0]  = up_quat.x * up_vec.x;
    m_nxt[1]  = up_quat.y * up_vec.y;
    m_nxt[2]  = up_quat.z * up_vec.z;
    m_nxt[3]  = up_quat.w * up_vec.x;
    m_nxt[4]  = up_quat.y * up_vec.z;
    m_nxt[5]  = up_quat.z * up_vec.y;
    m_nxt[6]  = up_quat.w * up_vec.y;
    m_nxt[7]  = up_quat.x * up_vec.z;
    m_nxt[8]  = up_quat.z * up_vec.x;
    m_nxt[9]  = up_quat.w * up_vec.z;
    m_nxt[10] = up_quat.x * up_vec.y;
    m_nxt[11] = up_quat.y * up_vec.x;
  end

  always_comb begin
    p_nxt.w = -P_W'(m_r[0]) - P_W'(m_r[1]) - P_W'(m_r[2]);
    p_nxt.x =  P_W'(m_r[3]) + P_W'(m_r[4]) - P_W'(m_r[5]);
    p_nxt.y =  P_W'(m_r[6]) - P_W'(m_r[7]) + P_W'(m_r[8]);
    p_nxt.z =  P_W'(m_r[9]) + P_W'(m_r[10]) - P_W'(m_r[11]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else begin
      if (en_a) begin
        va_r <= up_valid;
      end
      if (en_b) begin
        vb_r <= va_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_a && up_valid) begin
      m_r  <= m_nxt;
      qa_r <= up_quat;
    end
    if (en_b && va_r) begin
      p_r  <= p_nxt;
      qb_r <= qa_r;
    end
  end

  assign dn_valid = vb_r;
  assign dn_quat  = qb_r;
  assign dn_p     = p_r;

endmodule

[src/qrv_pc_mult.sv]
// Second product stage pair: partial products and sums of the vector part
// of r = p*conj(q). Depends on qrv_pkg.
`timescale 1ns / 1ps

module qrv_pc_mult (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            up_valid,
  output logic            up_ready,
  input  qrv_pkg::quat_t  up_quat,
  input  qrv_pkg::pquat_t up_p,
  output logic            dn_valid,
  input  logic            dn_ready,
  output qrv_pkg::rvec_t  dn_r
);
  import qrv_pkg::*;

  logic                      vc_r;
  logic                      vd_r;
  logic                      en_c;
  logic                      en_d;
  logic signed [PROD2_W-1:0] m_r [12];
  logic signed [PROD2_W-1:0] m_nxt [12];
  rvec_t                     r_r;
  rvec_t                     r_nxt;

  assign en_d     = !vd_r || dn_ready;
  assign en_c     = !vc_r || en_d;
  assign up_ready = en_c;

  always_comb begin
    m_nxt[0]  = up_p.w * up_quat.x;
    m_nxt[1]  = up_p.x * up_quat.w;
    m_nxt[2]  = up_p.y * up_quat.z;
    m_nxt[3]  = up_p.z * up_quat.y;
    m_nxt[4]  = up_p.w * up_quat.y;
    m_nxt[5]  = up_p.x * up_quat.z;
    m_nxt[6]  = up_p.y * up_quat.w;
    m_nxt[7]  = up_p.z * up_quat.x;
    m_nxt[8]  = up_p.w * up_quat.z;
    m_nxt[9]  = up_p.x * up_quat.y;
    m_nxt[10] = up_p.y * up_quat.x;
    m_nxt[11] = up_p.z * up_quat.w;
  end

  // The conjugate's signs are folded into the adds.
  always_comb begin
    r_nxt.x = -R_W'(m_r[0]) + R_W'(m_r[1]) - R_W'(m_r[2])  + R_W'(m_r[3]);
    r_nxt.y = -R_W'(m_r[4]) + R_W'(m_r[5]) + R_W'(m_r[6])  - R_W'(m_r[7]);
    r_nxt.z = -R_W'(m_r[8]) - R_W'(m_r[9]) + R_W'(m_r[10]) + R_W'(m_r[11]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
      vd_r <= 1'b0;
    end else begin
      if (en_c) begin
        vc_r <= up_valid;
      end
      if (en_d) begin
        vd_r <= vc_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en_c && up_valid) begin
      m_r <= m_nxt;
    end
    if (en_d && vc_r) begin
      r_r <= r_nxt;
    end
  end

  assign dn_valid = vd_r;
  assign dn_r     = r_r;

endmodule

[src/qrv_round_sat.sv]
// Output stage: rounds each component half up, saturates to 16 bits and
// holds the result transaction until it is taken. Depends on qrv_pkg.
`timescale 1ns / 1ps

module qrv_round_sat (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           up_valid,
  output logic           up_ready,
  input  qrv_pkg::rvec_t up_r,
  output logic           out_valid,
  input  logic           out_stall,
  output qrv_pkg::vec_t  out_rot,
  output logic           out_overflow
);
  import qrv_pkg::*;

  logic                    valid_r;
  logic                    en;
  vec_t                    rot_r;
  vec_t                    rot_nxt;
  logic                    ovf_r;
  logic                    ovf_nxt;
  logic signed [R_W-1:0]   comp [3];
  logic signed [R_W-1:0]   rnd [3];
  logic [2:0]              sat;
  logic signed [FIELD_W-1:0] res [3];

  assign en       = !valid_r || !out_stall;
  assign up_ready = en;

  always_comb begin
    comp[0] = up_r.x;
    comp[1] = up_r.y;
    comp[2] = up_r.z;
    for (int i = 0; i < 3; i++) begin
      // Arithmetic shift of the biased value is floor, so ties go up.
      rnd[i] = (comp[i] + ROUND_HALF) >>> FRAC_SHIFT;
      sat[i] = 1'b0;
      if (rnd[i] > SAT_MAX) begin
        res[i] = FIELD_W'(SAT_MAX);
        sat[i] = 1'b1;
      end else if (rnd[i] < SAT_MIN) begin
        res[i] = FIELD_W'(SAT_MIN);
        sat[i] = 1'b1;
      end else begin
        res[i] = rnd[i][FIELD_W-1:0];
      end
    end
    rot_nxt.x = res[0];
    rot_nxt.y = res[1];
    rot_nxt.z = res[2];
    ovf_nxt   = |sat;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en && up_valid) begin
      rot_r <= rot_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  assign out_valid    = valid_r;
  assign out_rot      = rot_r;
  assign out_overflow = ovf_r;

endmodule

[src/quaternion_rotate_vector.sv]
// Rotates a 16-bit vector by a Q2.14 quaternion as q*(0,v)*conj(q) and returns
// the vector part, rounded half up and saturated to 16 bits with an overflow
// flag; a non-unit quaternion also scales the vector by |q|^2. The datapath is
// a five-stage pipeline (two multiply/add pairs and a round/saturate stage):
// a transaction is accepted every cycle while the output is not stalled.
// Stalls back up stage by stage, and an empty stage is filled even while
// later stages are held.
`timescale 1ns / 1ps

module quaternion_rotate_vector (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic signed [15:0] in_quat_w,
  input  logic signed [15:0] in_quat_x,
  input  logic signed [15:0] in_quat_y,
  input  logic signed [15:0] in_quat_z,
  input  logic signed [15:0] in_vec_x,
  input  logic signed [15:0] in_vec_y,
  input  logic signed [15:0] in_vec_z,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [15:0] out_rot_x,
  output logic signed [15:0] out_rot_y,
  output logic signed [15:0] out_rot_z,
  output logic        out_overflow
);
  import qrv_pkg::*;

  quat_t  in_quat;
  vec_t   in_vec;
  logic   in_ready;
  logic   p_valid;
  logic   p_ready;
  quat_t  p_quat;
  pquat_t p_val;
  logic   r_valid;
  logic   r_ready;
  rvec_t  r_val;
  vec_t   rot;

  assign in_quat.w = in_quat_w;
  assign in_quat.x = in_quat_x;
  assign in_quat.y = in_quat_y;
  assign in_quat.z = in_quat_z;
  assign in_vec.x  = in_vec_x;
  assign in_vec.y  = in_vec_y;
  assign in_vec.z  = in_vec_z;
  assign in_stall  = !in_ready;

  qrv_qv_mult u_qv_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_quat  (in_quat),
    .up_vec   (in_vec),
    .dn_valid (p_valid),
    .dn_ready (p_ready),
    .dn_quat  (p_quat),
    .dn_p     (p_val)
  );

  qrv_pc_mult u_pc_mult (
    .clk      (clk),
    .rst_n    (rst_n),
    .up_valid (p_valid),
    .up_ready (p_ready),
    .up_quat  (p_quat),
    .up_p     (p_val),
    .dn_valid (r_valid),
    .dn_ready (r_ready),
    .dn_r     (r_val)
  );

  qrv_round_sat u_round_sat (
    .clk          (clk),
    .rst_n        (rst_n),
    .up_valid     (r_valid),
    .up_ready     (r_ready),
    .up_r         (r_val),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_rot      (rot),
    .out_overflow (out_overflow)
  );

  assign out_rot_x = rot.x;
  assign out_rot_y = rot.y;
  assign out_rot_z = rot.z;

endmodule

[tb/sv/quaternion_rotate_vector_tb.sv]
// Self-checking testbench for quaternion_rotate_vector (vector rotation by q*(0,v)*conj(q)).
// Runs a directed table and then random transactions against a 64-bit integer predictor.
// Depends on qrv_pkg and the quaternion_rotate_vector RTL.
`timescale 1ns / 1ps

module quaternion_rotate_vector_tb;
  import qrv_pkg::*;

  localparam int ROT_SHIFT = 28;
  localparam longint HALF_LSB = 64'sd134217728;  // 2^27, the rounding bias
  localparam int ITEMS_PER_PHASE = 467;
  localparam int SEND_IDLE_PCT [3] = '{38, 70, 0};
  localparam int RECV_STALL_PCT [3] = '{70, 38, 0};
  localparam int DIRECTED_COUNT = 16;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
    logic               ovf;
  } rot_t;

  // A transaction as offered to the block, with the typed answer when there is one.
  typedef struct packed {
    logic known;
    rot_t rot;
  } offer_t;

  typedef struct packed {
    logic signed [15:0] qw, qx, qy, qz, vx, vy, vz;
    logic               known;
    logic signed [15:0] ex, ey, ez;
    logic               eovf;
  } dir_row_t;

  // Q2.14: 16384 is 1.0, 8192 is 0.5, -32768 is -2.0.
  localparam dir_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{0, 0, 0, 0, 32767, -32768, 1, 1'b1, 0, 0, 0, 1'b0},
    '{16384, 0, 0, 0, 32767, -32768, -1, 1'b1, 32767, -32768, -1, 1'b0},
    '{-16384, 0, 0, 0, 32767, -32768, -1, 1'b1, 32767, -32768, -1, 1'b0},
    '{0, 0, 0, 16384, 100, 200, 300, 1'b1, -100, -200, 300, 1'b0},
    '{0, 0, 0, 16384, -32768, -32768, -32768, 1'b1, 32767, 32767, -32768, 1'b1},
    '{0, 16384, 0, 0, 5, -7, 9, 1'b1, 5, 7, -9, 1'b0},
    '{0, 0, 16384, 0, 5, -7, 9, 1'b1, -5, -7, -9, 1'b0},
    '{-32768, 0, 0, 0, 1, -1, 0, 1'b1, 4, -4, 0, 1'b0},
    '{-32768, 0, 0, 0, 32767, -32768, 8191, 1'b1, 32767, -32768, 32764, 1'b1},
    '{8192, 0, 0, 0, 2, -2, 1, 1'b1, 1, 0, 0, 1'b0},
    '{8192, 0, 0, 0, -1, 3, -3, 1'b1, 0, 1, -1, 1'b0},
    '{-32768, -32768, -32768, -32768, -32768, -32768, -32768, 1'b0, 0, 0, 0, 1'b0},
    '{32767, 32767, 32767, 32767, 32767, 32767, 32767, 1'b0, 0, 0, 0, 1'b0},
    '{11585, 0, 0, 11585, 1000, 0, 0, 1'b0, 0, 0, 0, 1'b0},
    '{-32768, 32767, -32768, 32767, 32767, 32767, -32768, 1'b0, 0, 0, 0, 1'b0},
    '{1, -1, 1, -1, -1, 1, -32768, 1'b0, 0, 0, 0, 1'b0}
  };

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_quat_w = '0;
  logic signed [15:0] in_quat_x = '0;
  logic signed [15:0] in_quat_y = '0;
  logic signed [15:0] in_quat_z = '0;
  logic signed [15:0] in_vec_x = '0;
  logic signed [15:0] in_vec_y = '0;
  logic signed [15:0] in_vec_z = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] out_rot_x;
  logic signed [15:0] out_rot_y;
  logic signed [15:0] out_rot_z;
  logic out_overflow;

  int idle_pct = 0;
  int stall_pct = 0;
  int fail_count = 0;
  int reported = 0;
  offer_t offered [$];
  rot_t expected_rot [$];

  quaternion_rotate_vector uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_quat_w    (in_quat_w),
    .in_quat_x    (in_quat_x),
    .in_quat_y    (in_quat_y),
    .in_quat_z    (in_quat_z),
    .in_vec_x     (in_vec_x),
    .in_vec_y     (in_vec_y),
    .in_vec_z     (in_vec_z),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_rot_x    (out_rot_x),
    .out_rot_y    (out_rot_y),
    .out_rot_z    (out_rot_z),
    .out_overflow (out_overflow)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5000000;
    $display("== FAIL ==");
    $finish;
  end

  // Exact rotation in 64-bit arithmetic; every intermediate fits well below 2^63.
  function automatic rot_t rotate_by_quat(input quat_t q, input vec_t v);
    longint w, i, j, k, vx, vy, vz, pw, px, py, pz, rounded;
    longint full [3];
    logic signed [15:0] lane [3];
    rot_t res;
    w = longint'($signed(q.w));
    i = longint'($signed(q.x));
    j = longint'($signed(q.y));
    k = longint'($signed(q.z));
    vx = longint'($signed(v.x));
    vy = longint'($signed(v.y));
    vz = longint'($signed(v.z));
    pw = -i * vx - j * vy - k * vz;
    px = w * vx + j * vz - k * vy;
    py = w * vy - i * vz + k * vx;
    pz = w * vz + i * vy - j * vx;
    full[0] = -pw * i + px * w - py * k + pz * j;
    full[1] = -pw * j + px * k + py * w - pz * i;
    full[2] = -pw * k - px * j + py * i + pz * w;
    res.ovf = 1'b0;
    for (int n = 0; n < 3; n++) begin
      // An arithmetic shift of a signed value is a floor, which gives round half up.
      rounded = (full[n] + HALF_LSB) >>> ROT_SHIFT;
      if (rounded > 32767) begin
        lane[n] = 16'sh7fff;
        res.ovf = 1'b1;
      end else if (rounded < -32768) begin
        lane[n] = 16'sh8000;
        res.ovf = 1'b1;
      end else begin
        lane[n] = rounded[15:0];
      end
    end
    res.x = lane[0];
    res.y = lane[1];
    res.z = lane[2];
    return res;
  endfunction

  task automatic note_failure(input string msg, input rot_t want, input rot_t got);
    fail_count++;
    if (reported < 10) begin
      reported++;
      $display("%0t: %s: expected x=%0d y=%0d z=%0d ovf=%0b, got x=%0d y=%0d z=%0d ovf=%0b",
               $time, msg, want.x, want.y, want.z, want.ovf, got.x, got.y, got.z, got.ovf);
    end
  endtask

  task automatic send_rotation(input quat_t q, input vec_t v, input offer_t o);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    offered.push_back(o);
    in_valid <= 1'b1;
    in_quat_w <= q.w;
    in_quat_x <= q.x;
    in_quat_y <= q.y;
    in_quat_z <= q.z;
    in_vec_x <= v.x;
    in_vec_y <= v.y;
    in_vec_z <= v.z;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // Both channels are sampled here, before any update of this edge takes effect.
  always @(posedge clk) begin : scoreboard
    offer_t o;
    rot_t want;
    rot_t got;
    if (rst_n && in_valid && !in_stall && offered.size() != 0) begin
      o = offered.pop_front();
      want = o.known ? o.rot : rotate_by_quat('{in_quat_w, in_quat_x, in_quat_y, in_quat_z},
                                              '{in_vec_x, in_vec_y, in_vec_z});
      expected_rot.push_back(want);
    end
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_rot_x, out_rot_y, out_rot_z, out_overflow};
      if (expected_rot.size() == 0) begin
        note_failure("result with no transaction pending", '0, got);
      end else begin
        want = expected_rot.pop_front();
        if (got !== want) note_failure("mismatch", want, got);
      end
    end
  end

  initial begin : stimulus
    logic signed [15:0] field [7];
    logic signed [15:0] corners [8];
    dir_row_t row;
    offer_t o;
    int shape;
    int drain;
    corners = '{-16'sd32768, -16'sd1, 16'sd0, 16'sd1, 16'sd32767, 16'sd16384,
                -16'sd16384, 16'sd8192};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = SEND_IDLE_PCT[phase];
      stall_pct = RECV_STALL_PCT[phase];
      if (phase == 0) begin
        for (int r = 0; r < DIRECTED_COUNT; r++) begin
          row = DIRECTED_ROWS[r];
          o.known = row.known;
          o.rot = '{row.ex, row.ey, row.ez, row.eovf};
          send_rotation('{row.qw, row.qx, row.qy, row.qz}, '{row.vx, row.vy, row.vz}, o);
        end
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        shape = $urandom_range(99);
        for (int f = 0; f < 7; f++) begin
          if (shape < 40) begin
            field[f] = 16'($urandom);
          end else if (shape < 80) begin
            // Moderate quaternions keep |q|^2 at most one, so most results do not saturate.
            field[f] = (f < 4) ? 16'(int'($urandom_range(16384)) - 8192) : 16'($urandom);
          end else begin
            field[f] = corners[$urandom_range(7)];
          end
        end
        o = '0;
        send_rotation('{field[0], field[1], field[2], field[3]},
                      '{field[4], field[5], field[6]}, o);
      end
    end
    in_valid <= 1'b0;

    drain = 0;
    while (expected_rot.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (12) @(posedge clk);
    if (expected_rot.size() != 0) begin
      fail_count++;
      $display("%0d transactions never produced a result", expected_rot.size());
    end
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
